FILE: src/nearest_preceding_address_lookup_macros.svh
// Assertion helpers for the nearest preceding address lookup.
// Each one samples on clk and is switched off while rst_n is low.
`ifndef NEAREST_PRECEDING_ADDRESS_LOOKUP_MACROS_SVH
`define NEAREST_PRECEDING_ADDRESS_LOOKUP_MACROS_SVH

// The consequent must hold in the same cycle as the antecedent.
`define NPAL_ASSERT_NOW(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error(msg);

// The consequent must hold in the cycle after the antecedent.
`define NPAL_ASSERT_NEXT(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error(msg);

`endif

FILE: src/npal_pkg.sv
package npal_pkg;

  localparam int ADDR_W        = 64;
  localparam int ENTRY_INDEX_W = 10;
  localparam int COUNT_W       = 11;
  localparam int MAX_ENTRIES   = 1024;

  localparam logic CMD_WRITE  = 1'b0;
  localparam logic CMD_LOOKUP = 1'b1;

  typedef enum logic [1:0] {
    ST_IDLE,
    ST_SCAN,
    ST_FINISH
  } npal_state_t;

endpackage

FILE: src/npal_ifs.sv
interface npal_in_if;
  logic                              valid;
  logic                              ready;
  logic                              command;
  logic [npal_pkg::ENTRY_INDEX_W-1:0] entry_index;
  logic [npal_pkg::ADDR_W-1:0]        entry_address;
  logic [npal_pkg::ADDR_W-1:0]        query_address;

  modport source (output valid, command, entry_index, entry_address, query_address,
                  input ready);
  modport sink (input valid, command, entry_index, entry_address, query_address,
                output ready);
endinterface

interface npal_out_if;
  logic                              valid;
  logic                              ready;
  logic                              found;
  logic [npal_pkg::ENTRY_INDEX_W-1:0] match_index;
  logic [npal_pkg::ADDR_W-1:0]        distance;

  modport source (output valid, found, match_index, distance, input ready);
  modport sink (input valid, found, match_index, distance, output ready);
endinterface

interface npal_cfg_if;
  logic                        valid;
  logic                        ready;
  logic [npal_pkg::COUNT_W-1:0] entry_count;

  modport source (output valid, entry_count, input ready);
  modport sink (input valid, entry_count, output ready);
endinterface

FILE: src/nearest_preceding_address_lookup.sv
// Channel  Direction  Payload
// in_ch    sink       command, entry_index, entry_address, query_address
// out_ch   source     found, match_index, distance
// cfg_ch   sink       entry_count
//
// A write request gives no result.
// A lookup request scans min(entry_count, MAX_ENTRIES) entries after it is accepted and
// registers its result at the end; with a count of zero no entry is read. The scan does
// one table read per cycle through the single read port, then a subtract stage and a
// compare stage. in_ch is not ready meanwhile.
// rst_n is synchronous; the table contents are not cleared by reset.
// A result waiting on a stalled out_ch holds the block in its final state.
`include "nearest_preceding_address_lookup_macros.svh"

module nearest_preceding_address_lookup #(
  parameter int MAX_ENTRIES = npal_pkg::MAX_ENTRIES
) (
  input logic         clk,
  input logic         rst_n,
  npal_in_if.sink     in_ch,
  npal_out_if.source  out_ch,
  npal_cfg_if.sink    cfg_ch
);

  localparam int IDX_W = (MAX_ENTRIES > 1) ? $clog2(MAX_ENTRIES) : 1;
  localparam int CNT_W = $clog2(MAX_ENTRIES + 1);

  npal_pkg::npal_state_t state_r, state_nxt;

  logic [npal_pkg::COUNT_W-1:0] entry_count_r;
  logic [npal_pkg::ADDR_W-1:0]  query_r;
  logic [CNT_W-1:0]             limit_r;
  logic [CNT_W-1:0]             limit_nxt;
  logic [CNT_W-1:0]             scan_idx_r;

  logic                         rd_vld_r;
  logic [IDX_W-1:0]             rd_idx_r;
  logic [npal_pkg::ADDR_W-1:0]  rd_data;

  logic                         diff_vld_r;
  logic [npal_pkg::ADDR_W-1:0]  diff_r;
  logic [IDX_W-1:0]             diff_idx_r;
  logic [npal_pkg::ADDR_W:0]    diff_full;

  logic                         best_hit_r;
  logic [npal_pkg::ADDR_W-1:0]  best_diff_r;
  logic [IDX_W-1:0]             best_idx_r;

  logic                         out_valid_r;
  logic                         out_found_r;
  logic [npal_pkg::ENTRY_INDEX_W-1:0] out_index_r;
  logic [npal_pkg::ADDR_W-1:0]  out_dist_r;

  logic in_acc;
  logic lookup_acc;
  logic wr_en;
  logic rd_en;
  logic out_free;
  logic load_out;
  logic scan_empty;

  assign in_acc     = in_ch.valid && in_ch.ready;
  assign lookup_acc = in_acc && (in_ch.command == npal_pkg::CMD_LOOKUP);
  assign wr_en      = in_acc && (in_ch.command == npal_pkg::CMD_WRITE) &&
                      (32'(in_ch.entry_index) < MAX_ENTRIES);
  assign out_free   = !out_valid_r || out_ch.ready;
  assign scan_empty = (scan_idx_r >= limit_r) && !rd_vld_r && !diff_vld_r;
  assign limit_nxt  = (32'(entry_count_r) > MAX_ENTRIES) ? CNT_W'(MAX_ENTRIES)
                                                          : CNT_W'(entry_count_r);

  // The user must write the configuration register only while idle; the block does not enforce it.
  assign cfg_ch.ready = 1'b1;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      entry_count_r <= '0;
    end else if (cfg_ch.valid) begin
      entry_count_r <= cfg_ch.entry_count;
    end
  end

  always_comb begin
    state_nxt = state_r;
    unique case (state_r)
      npal_pkg::ST_IDLE: begin
        if (lookup_acc) begin
          state_nxt = npal_pkg::ST_SCAN;
        end
      end
      npal_pkg::ST_SCAN: begin
        if (scan_empty) begin
          state_nxt = npal_pkg::ST_FINISH;
        end
      end
      npal_pkg::ST_FINISH: begin
        if (out_free) begin
          state_nxt = npal_pkg::ST_IDLE;
        end
      end
      default: state_nxt = npal_pkg::ST_IDLE;
    endcase
  end

  always_comb begin
    in_ch.ready = 1'b0;
    rd_en       = 1'b0;
    load_out    = 1'b0;
    unique case (state_r)
      npal_pkg::ST_IDLE:   in_ch.ready = 1'b1;
      npal_pkg::ST_SCAN:   rd_en       = (scan_idx_r < limit_r);
      npal_pkg::ST_FINISH: load_out    = out_free;
      default: ;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= npal_pkg::ST_IDLE;
    end else begin
      state_r <= state_nxt;
    end
  end

  npal_mem #(
    .DEPTH (MAX_ENTRIES),
    .AW    (IDX_W)
  ) u_mem (
    .clk     (clk),
    .wr_en   (wr_en),
    .wr_addr (IDX_W'(in_ch.entry_index)),
    .wr_data (in_ch.entry_address),
    .rd_en   (rd_en),
    .rd_addr (scan_idx_r[IDX_W-1:0]),
    .rd_data (rd_data)
  );

  // Read, subtract and compare stages of the scan.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      scan_idx_r <= '0;
      rd_vld_r   <= 1'b0;
      diff_vld_r <= 1'b0;
    end else begin
      if (lookup_acc) begin
        scan_idx_r <= '0;
      end else if (rd_en) begin
        scan_idx_r <= scan_idx_r + 1'b1;
      end
      rd_vld_r   <= rd_en;
      diff_vld_r <= rd_vld_r && !diff_full[npal_pkg::ADDR_W];
    end
  end

  assign diff_full = {1'b0, query_r} - {1'b0, rd_data};

  always_ff @(posedge clk) begin
    if (lookup_acc) begin
      query_r <= in_ch.query_address;
      limit_r <= limit_nxt;
    end
    rd_idx_r   <= scan_idx_r[IDX_W-1:0];
    diff_r     <= diff_full[npal_pkg::ADDR_W-1:0];
    diff_idx_r <= rd_idx_r;
  end

  // The best distance starts at all ones, so an entry at that distance never wins,
  // and the strict compare keeps the lowest index on a tie.
  always_ff @(posedge clk) begin
    if (lookup_acc) begin
      best_hit_r  <= 1'b0;
      best_diff_r <= '1;
      best_idx_r  <= '0;
    end else if (diff_vld_r && (diff_r < best_diff_r)) begin
      best_hit_r  <= 1'b1;
      best_diff_r <= diff_r;
      best_idx_r  <= diff_idx_r;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (load_out) begin
      out_valid_r <= 1'b1;
    end else if (out_ch.ready) begin
      out_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (load_out) begin
      out_found_r <= best_hit_r;
      out_index_r <= best_hit_r ? npal_pkg::ENTRY_INDEX_W'(best_idx_r) : '0;
      out_dist_r  <= best_hit_r ? best_diff_r : '0;
    end
  end

  assign out_ch.valid       = out_valid_r;
  assign out_ch.found       = out_found_r;
  assign out_ch.match_index = out_index_r;
  assign out_ch.distance    = out_dist_r;

  `NPAL_ASSERT_NEXT(a_lookup_starts_scan, lookup_acc, state_r == npal_pkg::ST_SCAN,
                    "lookup did not start a scan")
  `NPAL_ASSERT_NOW(a_result_from_finish, $rose(out_valid_r),
                   $past(state_r) == npal_pkg::ST_FINISH,
                   "result raised outside the final state")
  `NPAL_ASSERT_NOW(a_found_not_max, out_ch.valid && out_ch.found, out_ch.distance != '1,
                   "match at the maximal distance")
  `NPAL_ASSERT_NOW(a_miss_is_zero, out_ch.valid && !out_ch.found,
                   (out_ch.distance == '0) && (out_ch.match_index == '0),
                   "miss with non-zero payload")

endmodule

FILE: src/npal_mem.sv
module npal_mem #(
  parameter int DEPTH = npal_pkg::MAX_ENTRIES,
  parameter int AW    = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
  input  logic                        clk,
  input  logic                        wr_en,
  input  logic [AW-1:0]               wr_addr,
  input  logic [npal_pkg::ADDR_W-1:0] wr_data,
  input  logic                        rd_en,
  input  logic [AW-1:0]               rd_addr,
  output logic [npal_pkg::ADDR_W-1:0] rd_data
);

  logic [npal_pkg::ADDR_W-1:0] mem [0:DEPTH-1];
  logic [npal_pkg::ADDR_W-1:0] rd_data_r;

  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_addr] <= wr_data;
    end
  end

  always_ff @(posedge clk) begin
    if (rd_en) begin
      rd_data_r <= mem[rd_addr];
    end
  end

  assign rd_data = rd_data_r;

endmodule

FILE: sim/tb_top.sv
`timescale 1ns / 1ps

module tb_top;

  localparam int STALL_LIMIT   = 6000;
  localparam int SETTLE_CYCLES = 12;
  localparam int RANDOM_PHASES = 6;
  localparam int PHASE_ITEMS   = 70;
  localparam int FINAL_ITEMS   = 60;

  typedef struct packed {
    logic                               found;
    logic [npal_pkg::ENTRY_INDEX_W-1:0] match_index;
    logic [npal_pkg::ADDR_W-1:0]        distance;
  } lookup_result_t;

  typedef enum {ROW_WRITE, ROW_LOOKUP, ROW_SET_COUNT} row_kind_t;

  typedef struct {
    row_kind_t                          kind;
    logic [npal_pkg::ENTRY_INDEX_W-1:0] slot;
    logic [npal_pkg::ADDR_W-1:0]        value;
    bit                                 typed;
    lookup_result_t                     result;
  } stim_row_t;

  logic clk = 1'b0;
  logic rst_n;

  always #4 clk = ~clk;

  npal_in_if  in_ch ();
  npal_out_if out_ch ();
  npal_cfg_if cfg_ch ();

  nearest_preceding_address_lookup i_dut (
    .clk    (clk),
    .rst_n  (rst_n),
    .in_ch  (in_ch),
    .out_ch (out_ch),
    .cfg_ch (cfg_ch)
  );

  logic [npal_pkg::ADDR_W-1:0]  addr_copy [npal_pkg::MAX_ENTRIES];
  bit                           written [npal_pkg::MAX_ENTRIES];
  logic [npal_pkg::COUNT_W-1:0] count_copy;
  logic [npal_pkg::ADDR_W-1:0]  phase_base;
  lookup_result_t               pending_lookups [$];
  stim_row_t                    directed_rows [$];
  int                           mismatch_count = 0;
  int                           quiet_cycles = 0;
  int                           ready_hold = 0;
  bit                           calm = 1'b0;

  // Closest entry at or below the query among the entries in use; the lowest index wins a tie.
  function automatic lookup_result_t nearest_below(logic [npal_pkg::ADDR_W-1:0] query);
    lookup_result_t              r;
    logic [npal_pkg::ADDR_W-1:0] best;
    logic [npal_pkg::ADDR_W-1:0] gap;
    int                          limit;
    r     = '0;
    best  = '1;
    limit = (count_copy > npal_pkg::MAX_ENTRIES) ? npal_pkg::MAX_ENTRIES : int'(count_copy);
    for (int i = 0; i < limit; i++) begin
      if (addr_copy[i] <= query) begin
        gap = query - addr_copy[i];
        // A gap of all ones can never beat the starting value, so it never counts as found.
        if (gap < best) begin
          best          = gap;
          r.found       = 1'b1;
          r.match_index = npal_pkg::ENTRY_INDEX_W'(i);
        end
      end
    end
    if (r.found) r.distance = best;
    return r;
  endfunction

  function automatic int first_unwritten();
    for (int i = 0; i < npal_pkg::MAX_ENTRIES; i++) begin
      if (!written[i]) return i;
    end
    return npal_pkg::MAX_ENTRIES;
  endfunction

  // Mostly addresses clustered round the phase base, so that lookups both hit and miss.
  function automatic logic [npal_pkg::ADDR_W-1:0] pick_address();
    case ($urandom_range(0, 9))
      0: return '0;
      1: return '1;
      2, 3: return {$urandom, $urandom};
      default: return phase_base + npal_pkg::ADDR_W'($urandom_range(0, 4095));
    endcase
  endfunction

  function automatic void add_row(row_kind_t kind, logic [npal_pkg::ENTRY_INDEX_W-1:0] slot,
                                  logic [npal_pkg::ADDR_W-1:0] value, bit typed = 1'b0,
                                  logic found = 1'b0,
                                  logic [npal_pkg::ENTRY_INDEX_W-1:0] idx = '0,
                                  logic [npal_pkg::ADDR_W-1:0] want_dist = '0);
    stim_row_t row;
    row.kind   = kind;
    row.slot   = slot;
    row.value  = value;
    row.typed  = typed;
    row.result = {found, idx, want_dist};
    directed_rows.push_back(row);
  endfunction

  task automatic send_request(logic command, logic [npal_pkg::ENTRY_INDEX_W-1:0] slot,
                              logic [npal_pkg::ADDR_W-1:0] entry_addr,
                              logic [npal_pkg::ADDR_W-1:0] query,
                              bit typed, lookup_result_t typed_result);
    if (!calm && $urandom_range(0, 4) == 0) begin
      in_ch.valid <= 1'b0;
      repeat ($urandom_range(1, 19)) @(posedge clk);
    end
    in_ch.valid         <= 1'b1;
    in_ch.command       <= command;
    in_ch.entry_index   <= slot;
    in_ch.entry_address <= entry_addr;
    in_ch.query_address <= query;
    @(posedge clk);
    while (!in_ch.ready) @(posedge clk);
    if (command == npal_pkg::CMD_WRITE) begin
      addr_copy[slot] = entry_addr;
      written[slot]   = 1'b1;
    end else begin
      pending_lookups.push_back(typed ? typed_result : nearest_below(query));
    end
  endtask

  // The count is only changed once the block has drained and settled.
  task automatic set_entry_count(logic [npal_pkg::COUNT_W-1:0] value);
    in_ch.valid <= 1'b0;
    while (pending_lookups.size() != 0) @(posedge clk);
    repeat (SETTLE_CYCLES) @(posedge clk);
    cfg_ch.valid       <= 1'b1;
    cfg_ch.entry_count <= value;
    @(posedge clk);
    while (!cfg_ch.ready) @(posedge clk);
    cfg_ch.valid <= 1'b0;
    count_copy = value;
  endtask

  task automatic random_request();
    int top;
    if ($urandom_range(0, 99) < 55) begin
      send_request(npal_pkg::CMD_LOOKUP, npal_pkg::ENTRY_INDEX_W'($urandom),
                   {$urandom, $urandom}, pick_address(), 1'b0, '0);
    end else begin
      top = first_unwritten();
      if (top > npal_pkg::MAX_ENTRIES - 1) top = npal_pkg::MAX_ENTRIES - 1;
      send_request(npal_pkg::CMD_WRITE,
                   npal_pkg::ENTRY_INDEX_W'($urandom_range(0, 1) ? $urandom_range(0, top) :
                       $urandom_range(0, npal_pkg::MAX_ENTRIES - 1)),
                   pick_address(), {$urandom, $urandom}, 1'b0, '0);
    end
  endtask

  always @(posedge clk) begin
    if (calm) begin
      out_ch.ready <= 1'b1;
    end else if (ready_hold > 0) begin
      out_ch.ready <= 1'b0;
      ready_hold   <= ready_hold - 1;
    end else if ($urandom_range(0, 9) == 0) begin
      out_ch.ready <= 1'b0;
      ready_hold   <= $urandom_range(0, 18);
    end else begin
      out_ch.ready <= 1'b1;
    end
  end

  always @(posedge clk) begin
    lookup_result_t want;
    lookup_result_t got;
    bit             bad;
    if (rst_n && out_ch.valid && out_ch.ready) begin
      got = {out_ch.found, out_ch.match_index, out_ch.distance};
      if (pending_lookups.size() == 0) begin
        $display("%0t: result with no lookup outstanding: found %0b index %0d distance %h",
                 $time, got.found, got.match_index, got.distance);
        mismatch_count++;
      end else begin
        want = pending_lookups.pop_front();
        bad  = 1'b0;
        if (got.found !== want.found) begin
          $display("%0t: found expected %0b, got %0b", $time, want.found, got.found);
          bad = 1'b1;
        end
        if (got.match_index !== want.match_index) begin
          $display("%0t: match_index expected %0d, got %0d", $time, want.match_index,
                   got.match_index);
          bad = 1'b1;
        end
        if (got.distance !== want.distance) begin
          $display("%0t: distance expected %h, got %h", $time, want.distance, got.distance);
          bad = 1'b1;
        end
        if (bad) mismatch_count++;
      end
    end
  end

  always @(posedge clk) begin
    if (!rst_n || (in_ch.valid && in_ch.ready) || (out_ch.valid && out_ch.ready) ||
        (cfg_ch.valid && cfg_ch.ready)) begin
      quiet_cycles <= 0;
    end else if (quiet_cycles == STALL_LIMIT) begin
      $display("%0t: no request has moved for %0d cycles", $time, STALL_LIMIT);
      $display("Test completed with failures");
      $finish;
    end else begin
      quiet_cycles <= quiet_cycles + 1;
    end
  end

  initial begin
    logic [npal_pkg::COUNT_W-1:0] pick;
    int                           prefix;
    rst_n               <= 1'b0;
    in_ch.valid         <= 1'b0;
    in_ch.command       <= npal_pkg::CMD_WRITE;
    in_ch.entry_index   <= '0;
    in_ch.entry_address <= '0;
    in_ch.query_address <= '0;
    cfg_ch.valid        <= 1'b0;
    cfg_ch.entry_count  <= '0;
    count_copy = '0;
    phase_base = '0;
    repeat (6) @(posedge clk);
    rst_n <= 1'b1;

    // After reset the table is empty, then a single entry at zero, then ties and extremes.
    add_row(ROW_LOOKUP, 0, 64'd0, 1'b1);
    add_row(ROW_WRITE, 0, 64'd0);
    add_row(ROW_SET_COUNT, 0, 64'd1);
    add_row(ROW_LOOKUP, 0, '1, 1'b1);
    add_row(ROW_LOOKUP, 0, 64'd0, 1'b1, 1'b1, 10'd0, 64'd0);
    add_row(ROW_LOOKUP, 0, 64'h0123_4567_89AB_CDEF);
    add_row(ROW_WRITE, 1, '1);
    add_row(ROW_WRITE, 2, 64'd100);
    add_row(ROW_WRITE, 3, 64'd100);
    add_row(ROW_WRITE, 4, 64'h8000_0000_0000_0000);
    add_row(ROW_SET_COUNT, 0, 64'd5);
    add_row(ROW_LOOKUP, 0, '1, 1'b1, 1'b1, 10'd1, 64'd0);
    add_row(ROW_LOOKUP, 0, 64'd100, 1'b1, 1'b1, 10'd2, 64'd0);
    add_row(ROW_LOOKUP, 0, 64'd99, 1'b1, 1'b1, 10'd0, 64'd99);
    add_row(ROW_LOOKUP, 0, 64'hFFFF_FFFF_FFFF_FFFE);
    add_row(ROW_WRITE, 1023, 64'h5555_5555_5555_5555);
    add_row(ROW_WRITE, 512, 64'hAAAA_AAAA_AAAA_AAAA);
    add_row(ROW_LOOKUP, 0, 64'h7FFF_FFFF_FFFF_FFFF);
    add_row(ROW_SET_COUNT, 0, 64'd3);
    add_row(ROW_LOOKUP, 0, '1);

    foreach (directed_rows[i]) begin
      case (directed_rows[i].kind)
        ROW_SET_COUNT: begin
          set_entry_count(directed_rows[i].value[npal_pkg::COUNT_W-1:0]);
        end
        ROW_WRITE: begin
          send_request(npal_pkg::CMD_WRITE, directed_rows[i].slot, directed_rows[i].value,
                       {$urandom, $urandom}, 1'b0, '0);
        end
        default: begin
          send_request(npal_pkg::CMD_LOOKUP, npal_pkg::ENTRY_INDEX_W'($urandom),
                       {$urandom, $urandom}, directed_rows[i].value,
                       directed_rows[i].typed, directed_rows[i].result);
        end
      endcase
    end

    // Each phase extends the written prefix of the table, so that the count in use never
    // covers an entry that was never written.
    for (int p = 0; p < RANDOM_PHASES; p++) begin
      case ($urandom_range(0, 3))
        0: phase_base = npal_pkg::ADDR_W'($urandom_range(0, 4095));
        1: phase_base = '1 - npal_pkg::ADDR_W'($urandom_range(0, 4095));
        default: phase_base = {$urandom, $urandom};
      endcase
      repeat ($urandom_range(4, 24)) begin
        send_request(npal_pkg::CMD_WRITE, npal_pkg::ENTRY_INDEX_W'(first_unwritten()),
                     pick_address(), {$urandom, $urandom}, 1'b0, '0);
      end
      prefix = first_unwritten();
      if (p == 0) pick = '0;
      else if (p == 1) pick = npal_pkg::COUNT_W'(prefix);
      else pick = npal_pkg::COUNT_W'($urandom_range(1, prefix));
      set_entry_count(pick);
      repeat (PHASE_ITEMS) random_request();
    end

    // Final part without idling: scan the whole written prefix of the table.
    calm = 1'b1;
    set_entry_count(npal_pkg::COUNT_W'(first_unwritten()));
    repeat (FINAL_ITEMS) random_request();
    send_request(npal_pkg::CMD_LOOKUP, npal_pkg::ENTRY_INDEX_W'($urandom),
                 {$urandom, $urandom}, '1, 1'b0, '0);

    in_ch.valid <= 1'b0;
    while (pending_lookups.size() != 0) @(posedge clk);
    repeat (SETTLE_CYCLES) @(posedge clk);
    if (mismatch_count == 0) begin
      $display("Test completed successfully");
    end else begin
      $display("Test completed with failures");
    end
    $finish;
  end

endmodule
